// File: src/qrm_pkg.sv
// ----------------------------------------------------------------------------
// Quantile rank table package
// Shared types and constants for the quantile rank and mean table core.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int SUM_WIDTH = 48;
    localparam int IN_TDATA_WIDTH = 40;
    localparam int OUT_TDATA_WIDTH = 72;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_NORMALIZE = 1'b0;
    localparam logic REG_ACCUMULATE = 1'b1;

    typedef struct packed {
        logic ins;
        logic rot;
        logic shd;
    } t_cell_ctl;

endpackage

// File: src/qrm_cell.sv
// ----------------------------------------------------------------------------
// Sorter cell
// One entry of the sorted chain: inserts, rotates upward or shifts downward.
// ----------------------------------------------------------------------------
module qrm_cell import qrm_pkg::*; #(
    parameter int VW = 32,
    parameter int IW = 16,
    parameter int PW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [VW-1:0] i_ins_val,
    input  logic [IW-1:0] i_ins_idx,
    input  logic          i_prev_vld,
    input  logic          i_prev_gt,
    input  logic [VW-1:0] i_prev_val,
    input  logic [IW-1:0] i_prev_idx,
    input  logic [PW-1:0] i_prev_tag,
    input  logic          i_next_vld,
    input  logic [VW-1:0] i_next_val,
    input  logic [IW-1:0] i_next_idx,
    input  logic [PW-1:0] i_next_tag,
    output logic          o_vld,
    output logic [VW-1:0] o_val,
    output logic [IW-1:0] o_idx,
    output logic [PW-1:0] o_tag,
    output logic          o_gt
);

    logic          r_vld;
    logic [VW-1:0] r_val;
    logic [IW-1:0] r_idx;
    logic [PW-1:0] r_tag;
    logic          take_new;

    assign o_gt = r_vld && (r_val > i_ins_val);
    assign take_new = o_gt || (!r_vld && i_prev_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_prev_gt || take_new) begin
                r_vld <= 1'b1;
            end
        end else if (i_ctl.rot) begin
            r_vld <= i_prev_vld;
        end else if (i_ctl.shd) begin
            r_vld <= i_next_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                r_val <= i_prev_val;
                r_idx <= i_prev_idx;
            end else if (take_new) begin
                r_val <= i_ins_val;
                r_idx <= i_ins_idx;
            end
        end else if (i_ctl.rot) begin
            r_val <= i_prev_val;
            r_idx <= i_prev_idx;
            r_tag <= i_prev_tag;
        end else if (i_ctl.shd) begin
            r_val <= i_next_val;
            r_idx <= i_next_idx;
            r_tag <= i_next_tag;
        end
    end

    assign o_vld = r_vld;
    assign o_val = r_val;
    assign o_idx = r_idx;
    assign o_tag = r_tag;

endmodule

// File: src/qrm_sums.sv
// ----------------------------------------------------------------------------
// Rank sum memory
// Per-rank accumulated sums with registered read; unwritten entries read zero.
// ----------------------------------------------------------------------------
module qrm_sums import qrm_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [SUM_WIDTH-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [SUM_WIDTH-1:0] i_wr_data
);

    logic [SUM_WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_written;
    logic [SUM_WIDTH-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: src/quantile_rank_and_mean_table_core.sv
// ----------------------------------------------------------------------------
// Quantile rank and mean table core
// Sorts one chip's probe samples in a chain of cells and emits tie-averaged
// ranks together with saturating per-rank mean sums.
//
// The slave stream carries load and query beats (tuser is the command). A load
// beat is inserted into the sorted chain at once. The beat with tlast set ends
// the chip: the chain then rotates once through all MAX_ENTRIES cells to find
// the end of each tie group, and then drains one result beat per entry, reading
// the rank sum memory in ST_RD and, when accumulating, writing it in ST_WR. A
// query beat gives one result beat, read from the rank sum memory and then
// registered at the output. The slave side is not ready while the chain
// rotates, a chip is drained or a query is pending. The master side holds its
// beat while tready is low and the drain waits. Reset clears the chain, the
// counters and the sums, and sets accumulation on; no clearing pass is needed.
// The configuration channel is always ready.
// ----------------------------------------------------------------------------
module quantile_rank_and_mean_table_core import qrm_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // sample[31:0], is_control[32], rank_query[38:33], zero pad
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                       s_axis_tuser,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // probe_index[15:0], rank_index[21:16], mean_sum[69:22], zero pad
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic                       i_cfg_data
);

    localparam int PW = $clog2(MAX_ENTRIES);
    localparam int CW = PW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_QOUT = 3'd4;

    logic [2:0]             r_state;
    logic [CW-1:0]          r_cnt;
    logic [INDEX_WIDTH-1:0] r_probe;
    logic                   r_norm;
    logic                   r_acc;
    logic [PW-1:0]          r_j;
    logic [VALUE_WIDTH-1:0] r_prev_val;
    logic                   r_have_prev;
    logic [PW-1:0]          r_last;
    logic [PW-1:0]          r_p;
    logic [PW-1:0]          r_first;
    logic                   r_q_oor;
    logic                   r_out_vld;
    logic [15:0]            r_out_probe;
    logic [5:0]             r_out_rank;
    logic [SUM_WIDTH-1:0]   r_out_sum;
    logic                   r_out_last;

    logic                   in_fire;
    logic                   load_fire;
    logic                   query_fire;
    logic                   keep;
    logic [31:0]            in_sample;
    logic                   in_is_control;
    logic [5:0]             in_rank_query;
    logic [VALUE_WIDTH-1:0] ins_val;
    t_cell_ctl              ctl;
    logic                   out_free;
    logic                   out_load;

    logic                   c_vld [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] c_val [MAX_ENTRIES];
    logic [INDEX_WIDTH-1:0] c_idx [MAX_ENTRIES];
    logic [PW-1:0]          c_tag [MAX_ENTRIES];
    logic                   c_gt  [MAX_ENTRIES];

    logic [PW-1:0]          rot_tag;
    logic                   rot_new_group;
    logic                   drain_new_group;
    logic [PW-1:0]          drain_first;
    logic [CW-1:0]          rank_sum;
    logic [PW-1:0]          rank_pos;
    logic [SUM_WIDTH:0]     acc_sum;
    logic [SUM_WIDTH-1:0]   new_sum;
    logic [SUM_WIDTH-1:0]   rd_data;
    logic                   rd_en;
    logic [PW-1:0]          rd_addr;
    logic                   wr_en;
    logic [39:0]            idx_ext;

    assign in_sample     = s_axis_tdata[31:0];
    assign in_is_control = s_axis_tdata[32];
    assign in_rank_query = s_axis_tdata[38:33];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign load_fire  = in_fire && (s_axis_tuser == CMD_LOAD);
    assign query_fire = in_fire && (s_axis_tuser == CMD_QUERY);
    assign keep = (r_norm || !in_is_control) && (r_cnt < CW'(MAX_ENTRIES));
    assign ins_val = VALUE_WIDTH'(in_sample);
    assign out_free = !r_out_vld || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign ctl.ins = load_fire && keep;
    assign ctl.rot = (r_state == ST_ROT);
    assign ctl.shd = (r_state == ST_WR) && out_free;

    assign out_load = ctl.shd || ((r_state == ST_QOUT) && out_free);

    assign rot_new_group = !r_have_prev || (c_val[MAX_ENTRIES-1] != r_prev_val);
    assign rot_tag = rot_new_group ? r_j : r_last;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            logic                   p_vld;
            logic                   p_gt;
            logic [VALUE_WIDTH-1:0] p_val;
            logic [INDEX_WIDTH-1:0] p_idx;
            logic [PW-1:0]          p_tag;
            logic                   q_vld;
            logic [VALUE_WIDTH-1:0] q_val;
            logic [INDEX_WIDTH-1:0] q_idx;
            logic [PW-1:0]          q_tag;
            if (gi == 0) begin : g_head
                assign p_vld = ctl.rot ? c_vld[MAX_ENTRIES-1] : 1'b1;
                assign p_gt  = 1'b0;
                assign p_val = c_val[MAX_ENTRIES-1];
                assign p_idx = c_idx[MAX_ENTRIES-1];
                assign p_tag = rot_tag;
            end else begin : g_body
                assign p_vld = c_vld[gi-1];
                assign p_gt  = c_gt[gi-1];
                assign p_val = c_val[gi-1];
                assign p_idx = c_idx[gi-1];
                assign p_tag = c_tag[gi-1];
            end
            if (gi == MAX_ENTRIES - 1) begin : g_tail
                assign q_vld = 1'b0;
                assign q_val = c_val[gi];
                assign q_idx = c_idx[gi];
                assign q_tag = c_tag[gi];
            end else begin : g_inner
                assign q_vld = c_vld[gi+1];
                assign q_val = c_val[gi+1];
                assign q_idx = c_idx[gi+1];
                assign q_tag = c_tag[gi+1];
            end
            qrm_cell #(
                .VW(VALUE_WIDTH),
                .IW(INDEX_WIDTH),
                .PW(PW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_ins_val  (ins_val),
                .i_ins_idx  (r_probe),
                .i_prev_vld (p_vld),
                .i_prev_gt  (p_gt),
                .i_prev_val (p_val),
                .i_prev_idx (p_idx),
                .i_prev_tag (p_tag),
                .i_next_vld (q_vld),
                .i_next_val (q_val),
                .i_next_idx (q_idx),
                .i_next_tag (q_tag),
                .o_vld      (c_vld[gi]),
                .o_val      (c_val[gi]),
                .o_idx      (c_idx[gi]),
                .o_tag      (c_tag[gi]),
                .o_gt       (c_gt[gi])
            );
        end
    endgenerate

    assign drain_new_group = !r_have_prev || (c_val[0] != r_prev_val);
    assign drain_first = drain_new_group ? r_p : r_first;
    assign rank_sum = CW'(drain_first) + CW'(c_tag[0]);
    assign rank_pos = rank_sum[CW-1:1];
    assign acc_sum = {1'b0, rd_data} + (SUM_WIDTH + 1)'(c_val[0]);
    assign new_sum = !r_acc ? rd_data :
                     (acc_sum[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : acc_sum[SUM_WIDTH-1:0]);
    assign idx_ext = 40'(c_idx[0]);

    assign rd_en = query_fire || ((r_state == ST_RD) && c_vld[0]);
    assign rd_addr = (r_state == ST_RD) ? r_p : in_rank_query[PW-1:0];
    assign wr_en = ctl.shd && r_acc;

    qrm_sums #(
        .DEPTH(MAX_ENTRIES),
        .AW(PW)
    ) u_sums (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_p),
        .i_wr_data (new_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_probe     <= '0;
            r_norm      <= 1'b0;
            r_acc       <= 1'b1;
            r_j         <= '0;
            r_have_prev <= 1'b0;
            r_last      <= '0;
            r_p         <= '0;
            r_first     <= '0;
            r_q_oor     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_NORMALIZE) begin
                    r_norm <= i_cfg_data;
                end else begin
                    r_acc <= i_cfg_data;
                end
            end
            r_out_vld <= out_load || (r_out_vld && !m_axis_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (load_fire) begin
                        r_probe <= r_probe + 1'b1;
                        if (keep) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_state     <= ST_ROT;
                            r_j         <= PW'(MAX_ENTRIES - 1);
                            r_have_prev <= 1'b0;
                        end
                    end else if (query_fire) begin
                        r_q_oor <= {1'b0, in_rank_query} >= 7'(MAX_ENTRIES);
                        r_state <= ST_QOUT;
                    end
                end
                ST_ROT: begin
                    r_j <= r_j - 1'b1;
                    if (r_j == '0) begin
                        r_state     <= ST_RD;
                        r_have_prev <= 1'b0;
                        r_p         <= '0;
                    end else if (c_vld[MAX_ENTRIES-1]) begin
                        r_last      <= rot_tag;
                        r_have_prev <= 1'b1;
                    end
                end
                ST_RD: begin
                    if (c_vld[0]) begin
                        r_state <= ST_WR;
                    end else begin
                        r_state <= ST_IDLE;
                        r_cnt   <= '0;
                        r_probe <= '0;
                    end
                end
                ST_WR: begin
                    if (out_free) begin
                        r_first     <= drain_first;
                        r_have_prev <= 1'b1;
                        r_p         <= r_p + 1'b1;
                        r_state     <= ST_RD;
                    end
                end
                ST_QOUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_ROT) && c_vld[MAX_ENTRIES-1]) begin
            r_prev_val <= c_val[MAX_ENTRIES-1];
        end else if (ctl.shd) begin
            r_prev_val <= c_val[0];
        end
        if (ctl.shd) begin
            r_out_probe <= idx_ext[15:0];
            r_out_rank  <= 6'(rank_pos);
            r_out_sum   <= new_sum;
            r_out_last  <= (MAX_ENTRIES > 1) ? !c_vld[1] : 1'b1;
        end else if ((r_state == ST_QOUT) && out_free) begin
            r_out_probe <= '0;
            r_out_rank  <= '0;
            r_out_sum   <= r_q_oor ? '0 : rd_data;
            r_out_last  <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_sum, r_out_rank, r_out_probe};
    assign m_axis_tlast  = r_out_last;

endmodule
